FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the oscillator RTL.
// Depends on nothing; every macro samples on the rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define MWO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion name failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define MWO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion name failed");

`endif

FILE: rtl/core/mwo_pkg.sv
// Package for the multi-waveform oscillator: sizes, register and shape codes,
// and the elaboration-time builder of the quarter-wave sine table. No dependencies.
package mwo_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
  localparam int TBL_ADDR_W      = TABLE_ADDR_BITS + 1;
  localparam int TRI_EXT_W       = PHASE_BITS - 2 + 15;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Full-scale wave value, 1.0 in the wave's fixed-point format.
  localparam logic [16:0] UNIT = 17'd32768;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_shape_t;

  typedef enum logic [1:0] {
    REG_WAVE_SHAPE = 2'd0,
    REG_PHASE_STEP = 2'd1,
    REG_AMPLITUDE  = 2'd2
  } reg_index_t;

  // Read request to the sine ROM.
  typedef struct packed {
    logic                  en;
    logic [TBL_ADDR_W-1:0] addr;
  } rom_req_t;

  typedef logic [14:0] sine_rom_t [TBL_N+1];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;
  localparam logic [63:0] SINE_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // Q30 Taylor series of sin over a quarter wave, rounded to Q15 and clamped.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   tbl;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] e;
    for (int k = 0; k <= TBL_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / SINE_DIV[n];
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      e = (s * 64'd32767 + Q30_HALF) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tbl[k] = e[14:0];
    end
    return tbl;
  endfunction

endpackage

FILE: rtl/core/mwo_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
// Depends on mwo_pkg for the table size and its contents.
module mwo_sine_rom (
  input  logic                clk,
  input  mwo_pkg::rom_req_t   req,
  output logic [14:0]         data_r
);

  localparam mwo_pkg::sine_rom_t ROM = mwo_pkg::build_sine_rom();

  // The read register holds while the enable is low, so a stalled pipeline keeps its value.
  always_ff @(posedge clk) begin
    if (req.en) begin
      data_r <= ROM[req.addr];
    end
  end

endmodule

FILE: rtl/core/multi_waveform_oscillator_unit.sv
// Top level of the multi-waveform phase-accumulator oscillator.
// Depends on mwo_pkg, mwo_sine_rom and assert_macros.svh.

// Direct digital synthesis oscillator: each input transaction produces exactly one signed
// 16-bit sample in out_tdata. Bit 0 of in_tdata (restart) clears the phase to zero before
// that transaction's sample is formed; after the sample the phase advances by phase_step
// modulo 2^32. wave_shape selects sine (quarter-wave table, no interpolation), square
// (zero at phase zero and at exactly half a cycle), triangle, or descending sawtooth; the
// wave value is scaled by amplitude and shifted right by 15, truncating toward zero. The
// block accepts one transaction per clock cycle and sustains that rate while out_tready is
// high; a sample passes from its input transaction through the stage 1 registers, with the
// registered sine ROM read, and then the amplitude multiply into the output register. Output
// back-pressure stalls the two stages together and deasserts in_tready only when both
// are full. There is no clearing pass after reset. Registers lie at byte addresses 0
// (wave_shape), 4 (phase_step) and 8 (amplitude); writes to address 12 are ignored and
// read back as zero. Registers should be written only while no transaction is in flight.
`include "assert_macros.svh"

module multi_waveform_oscillator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,     // [0] restart, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,    // [15:0] sample (signed)
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mwo_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mwo_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PB  = mwo_pkg::PHASE_BITS;
  localparam int TAB = mwo_pkg::TABLE_ADDR_BITS;
  localparam int TW  = mwo_pkg::TBL_ADDR_W;
  localparam int TRI_EXT_W_L = mwo_pkg::TRI_EXT_W;

  // Configuration registers.
  logic [1:0]    wave_shape_r;
  logic [31:0]   phase_step_r;
  logic [14:0]   amplitude_r;

  // Phase accumulator, the block's only state that carries from sample to sample.
  logic [PB-1:0] phase_r;
  logic [PB-1:0] phase_nxt;

  // Stage 1: wave magnitude and sign, or a pending ROM read for the sine.
  logic          s1_valid_r;
  logic          s1_sine_r;
  logic          s1_neg_r;
  logic [15:0]   s1_mag_r;

  // Output register.
  logic          out_valid_r;
  logic [15:0]   out_sample_r;

  logic          cfg_write;
  logic          in_accept;
  logic          out_load;
  logic          s1_load;

  logic [PB-1:0]        phase_cur;
  logic [1:0]           quad;
  logic [TAB-1:0]       tbl_lo;
  logic [TRI_EXT_W_L-1:0] tri_ext;
  logic [14:0]          tri_m;
  logic [16:0]          saw_diff;
  logic [15:0]          mag0;
  logic                 neg0;
  logic                 sine0;

  mwo_pkg::rom_req_t    rom_req;
  logic [14:0]          rom_data;

  logic [15:0]          mag1;
  logic [30:0]          prod;
  logic [15:0]          scaled;

  // ---------------------------------------------------------------------------
  // Configuration port. pready is tied high, so the access cycle completes at once.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r <= 2'd0;
      phase_step_r <= 32'd0;
      amplitude_r  <= 15'd0;
    end else if (cfg_write) begin
      unique case (cfg_paddr[3:2])
        mwo_pkg::REG_WAVE_SHAPE: wave_shape_r <= cfg_pwdata[1:0];
        mwo_pkg::REG_PHASE_STEP: phase_step_r <= cfg_pwdata[31:0];
        mwo_pkg::REG_AMPLITUDE:  amplitude_r  <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      mwo_pkg::REG_WAVE_SHAPE: cfg_prdata = {30'd0, wave_shape_r};
      mwo_pkg::REG_PHASE_STEP: cfg_prdata = phase_step_r;
      mwo_pkg::REG_AMPLITUDE:  cfg_prdata = {17'd0, amplitude_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. The output register loads when it is empty or being drained;
  // stage 1 moves whenever it is empty or the output register takes its content.
  // ---------------------------------------------------------------------------
  assign out_load  = !out_valid_r || out_tready;
  assign s1_load   = !s1_valid_r || out_load;
  assign in_tready = s1_load;
  assign in_accept = in_tvalid & in_tready;

  // ---------------------------------------------------------------------------
  // Stage 0: phase selection, accumulator update and per-shape magnitude.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_cur = in_tdata[0] ? '0 : phase_r;
    phase_nxt = phase_cur + PB'(phase_step_r);
    quad      = phase_cur[PB-1 -: 2];
    tbl_lo    = phase_cur[PB-3 -: TAB];

    // Phase within the quadrant scaled to 15 bits by truncation.
    tri_ext   = {phase_cur[PB-3:0], 15'd0};
    tri_m     = tri_ext[TRI_EXT_W_L-1 -: 15];

    // Sawtooth runs from full scale down through zero as the top phase bits rise.
    saw_diff  = mwo_pkg::UNIT - {1'b0, phase_cur[PB-1 -: 16]};

    rom_req.en   = s1_load;
    rom_req.addr = quad[0] ? (TW'(mwo_pkg::TBL_N) - {1'b0, tbl_lo}) : {1'b0, tbl_lo};

    sine0 = 1'b0;
    unique case (wave_shape_r)
      mwo_pkg::WAVE_SINE: begin
        sine0 = 1'b1;
        mag0  = 16'd0;
        neg0  = quad[1];
      end
      mwo_pkg::WAVE_SQUARE: begin
        // Exactly zero at phase zero and at half a cycle, where the sine is zero.
        if (phase_cur[PB-2:0] == '0) begin
          mag0 = 16'd0;
        end else begin
          mag0 = mwo_pkg::UNIT[15:0];
        end
        neg0 = phase_cur[PB-1];
      end
      mwo_pkg::WAVE_TRIANGLE: begin
        mag0 = quad[0] ? 16'(mwo_pkg::UNIT - {2'd0, tri_m}) : {1'b0, tri_m};
        neg0 = quad[1];
      end
      default: begin
        neg0 = saw_diff[16];
        mag0 = saw_diff[16] ? 16'(17'd0 - saw_diff) : saw_diff[15:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
    end
  end

  mwo_sine_rom u_sine_rom (
    .clk    (clk),
    .req    (rom_req),
    .data_r (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sine_r <= sine0;
      s1_neg_r  <= neg0;
      s1_mag_r  <= mag0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: amplitude scaling. The product is truncated on the magnitude, so the
  // signed result truncates toward zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    mag1   = s1_sine_r ? {1'b0, rom_data} : s1_mag_r;
    prod   = 31'(mag1) * 31'(amplitude_r);
    scaled = prod[30:15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= s1_neg_r ? 16'(16'd0 - scaled) : scaled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `MWO_ASSERT_NXT(a_restart_phase, clk, rst_n, in_accept && in_tdata[0] && !cfg_write,
                  phase_r == PB'($past(phase_step_r)))
  `MWO_ASSERT_NXT(a_phase_advance, clk, rst_n, in_accept && !in_tdata[0],
                  phase_r == PB'($past(phase_r) + PB'($past(phase_step_r))))
  `MWO_ASSERT_NXT(a_phase_hold, clk, rst_n, !in_accept, $stable(phase_r))
  `MWO_ASSERT_NXT(a_stage_hold, clk, rst_n, s1_valid_r && !out_load,
                  s1_valid_r && $stable(rom_data) && $stable(s1_mag_r))
  `MWO_ASSERT_IMP(a_full_blocks_input, clk, rst_n, s1_valid_r && out_valid_r && !out_tready,
                  !in_tready)

endmodule
